FILE: hw/rtl/msc_pkg.sv
package msc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_BANDWIDTH = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;

  localparam logic [30:0] BANDWIDTH_RST = 31'd65536;
  localparam logic [15:0] THRESHOLD_RST = 16'd1;
  localparam logic [7:0]  ITER_LIMIT_RST = 8'd100;

  // round(2^32 * exp(-2^(b-16))) for each bit b of the Q5.16 kernel ratio
  localparam int unsigned EXP_BITS = 21;
  localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483
  };

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               set_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mode_x;
    logic signed [31:0] mode_y;
    logic signed [31:0] mode_z;
    logic               final_point;
    logic [7:0]         passes_used;
  } out_t;

endpackage

FILE: hw/rtl/msc_ram.sv
module msc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/mean_shift_cluster_engine.sv
// points load at one per cycle; a word with set_end high starts the run and raises busy
// a pass shifts each still-moving point against all n loaded points, using one shared
// 34x34 multiplier and one restoring divide/compare unit; the run first copies the loaded set
// results follow as n strobes read through the moved store read port, receiver cannot stall
// reset clears the point count, sets every moving flag and returns the config registers to their defaults
module mean_shift_cluster_engine #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  msc_pkg::in_t   item_i,
  output logic           result_valid_o,
  output msc_pkg::out_t  result_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import msc_pkg::*;

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [22:0] {
    S_IDLE     = 23'd1 << 0,
    S_DEN      = 23'd1 << 1,
    S_TH2      = 23'd1 << 2,
    S_COPY_RD  = 23'd1 << 3,
    S_COPY_WR  = 23'd1 << 4,
    S_PASS     = 23'd1 << 5,
    S_PT_CHK   = 23'd1 << 6,
    S_PT_LD    = 23'd1 << 7,
    S_SRC_RD   = 23'd1 << 8,
    S_SRC_LD   = 23'd1 << 9,
    S_SQ       = 23'd1 << 10,
    S_KCHK     = 23'd1 << 11,
    S_KDIV     = 23'd1 << 12,
    S_KEXP     = 23'd1 << 13,
    S_ACC      = 23'd1 << 14,
    S_MEAN     = 23'd1 << 15,
    S_DIV_INIT = 23'd1 << 16,
    S_DIV      = 23'd1 << 17,
    S_PT_WR    = 23'd1 << 18,
    S_PT_NEXT  = 23'd1 << 19,
    S_PASS_END = 23'd1 << 20,
    S_OUT_RD   = 23'd1 << 21,
    S_OUT      = 23'd1 << 22
  } state_e;

  function automatic logic signed [31:0] sel3(input logic [1:0] c,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic signed [31:0] d);
    logic signed [31:0] r;
    case (c)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = d;
    endcase
    return r;
  endfunction

  // control state
  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MAX_POINTS-1:0] still_q, still_d;
  logic [30:0] bw_q, bw_d;
  logic [15:0] th_q, th_d;
  logic [7:0] lim_q, lim_d;
  logic res_valid_q, res_valid_d;

  // datapath
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0] c_q, c_d;
  logic [4:0] k_q, k_d;
  logic dist_q, dist_d, neg_q, neg_d;
  logic [62:0] den_q, den_d;
  logic [31:0] th2_q, th2_d;
  logic [7:0] passes_q, passes_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic signed [31:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic signed [31:0] nx_q, nx_d, ny_q, ny_d, nz_q, nz_d;
  logic [63:0] d2_q, d2_d, worst_q, worst_d;
  logic [79:0] rem_q, rem_d;
  logic [82:0] dvs_q, dvs_d;
  logic [20:0] r_q, r_d;
  logic [32:0] w_q, w_d;
  logic [31:0] q_q, q_d;
  logic signed [63:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic [30:0] wsum_q, wsum_d;
  out_t res_q, res_d;

  // stores
  logic src_we, mov_we;
  logic [IW-1:0] mov_waddr;
  logic [95:0] mov_wdata, src_rdata, mov_rdata;

  // shared units
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [31:0] sq_a, sq_b;
  logic signed [32:0] sq_diff;
  logic [32:0] sq_mag;
  logic [64:0] sq_sum;
  logic div_ge;
  logic [79:0] rem_sub;
  logic [65:0] exp_rnd;
  logic [33:0] wt_rnd;
  logic [24:0] wt;
  logic [CW-1:0] n_last;
  logic last_i, last_j;
  logic signed [63:0] num;
  logic [63:0] num_mag;
  logic [31:0] q_fin;

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = ~busy;
  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

  assign mul_p = mul_a * mul_b;
  assign n_last = cnt_q - CW'(1);
  assign last_i = (CW'(i_q) == n_last);
  assign last_j = (CW'(j_q) == n_last);

  assign sq_a = dist_q ? sel3(c_q, nx_q, ny_q, nz_q) : sel3(c_q, px_q, py_q, pz_q);
  assign sq_b = dist_q ? sel3(c_q, px_q, py_q, pz_q) : sel3(c_q, sx_q, sy_q, sz_q);
  assign sq_diff = {sq_a[31], sq_a} - {sq_b[31], sq_b};
  assign sq_mag = sq_diff[32] ? (33'd0 - sq_diff) : sq_diff;
  assign sq_sum = {1'b0, d2_q} + {1'b0, mul_p[63:0]};

  assign div_ge = ({3'b0, rem_q} >= dvs_q);
  assign rem_sub = rem_q - dvs_q[79:0];
  assign exp_rnd = {1'b0, mul_p[64:0]} + 66'h80000000;
  assign wt_rnd = {1'b0, w_q} + 34'd128;
  assign wt = wt_rnd[32:8];

  always_comb begin
    case (c_q)
      2'd0:    num = ax_q;
      2'd1:    num = ay_q;
      default: num = az_q;
    endcase
  end
  assign num_mag = num[63] ? (64'd0 - num) : num;
  assign q_fin = neg_q ? (32'd0 - {q_q[30:0], div_ge}) : {q_q[30:0], div_ge};

  msc_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({item_i.coord_x, item_i.coord_y, item_i.coord_z}),
    .raddr_i (j_q),
    .rdata_o (src_rdata)
  );

  msc_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_mov_ram (
    .clk_i   (clk_i),
    .we_i    (mov_we),
    .waddr_i (mov_waddr),
    .wdata_i (mov_wdata),
    .raddr_i (i_q),
    .rdata_o (mov_rdata)
  );

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    still_d = still_q;
    bw_d = bw_q;
    th_d = th_q;
    lim_d = lim_q;
    res_valid_d = 1'b0;
    i_d = i_q;
    j_d = j_q;
    c_d = c_q;
    k_d = k_q;
    dist_d = dist_q;
    neg_d = neg_q;
    den_d = den_q;
    th2_d = th2_q;
    passes_d = passes_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q;
    sx_d = sx_q; sy_d = sy_q; sz_d = sz_q;
    nx_d = nx_q; ny_d = ny_q; nz_d = nz_q;
    d2_d = d2_q;
    worst_d = worst_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    r_d = r_q;
    w_d = w_q;
    q_d = q_q;
    ax_d = ax_q; ay_d = ay_q; az_d = az_q;
    wsum_d = wsum_q;
    res_d = res_q;
    src_we = 1'b0;
    mov_we = 1'b0;
    mov_waddr = i_q;
    mov_wdata = {nx_q, ny_q, nz_q};
    mul_a = '0;
    mul_b = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BANDWIDTH:  bw_d = cfg_data_i[30:0];
        CFG_THRESHOLD:  th_d = cfg_data_i[15:0];
        CFG_ITER_LIMIT: lim_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cnt_q < CW'(MAX_POINTS)) begin
            src_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
          if (item_i.set_end) begin
            state_d = S_DEN;
          end
        end
      end
      S_DEN: begin
        mul_a = {3'b0, bw_q};
        mul_b = {3'b0, bw_q};
        den_d = {mul_p[61:0], 1'b0};
        passes_d = '0;
        state_d = S_TH2;
      end
      S_TH2: begin
        mul_a = {18'b0, th_q};
        mul_b = {18'b0, th_q};
        th2_d = mul_p[31:0];
        j_d = '0;
        state_d = S_COPY_RD;
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: begin
        mov_we = 1'b1;
        mov_waddr = j_q;
        mov_wdata = src_rdata;
        if (last_j) begin
          state_d = S_PASS;
        end else begin
          j_d = j_q + IW'(1);
          state_d = S_COPY_RD;
        end
      end
      S_PASS: begin
        i_d = '0;
        worst_d = '0;
        state_d = S_PT_CHK;
      end
      S_PT_CHK: state_d = still_q[i_q] ? S_PT_LD : S_PT_NEXT;
      S_PT_LD: begin
        px_d = mov_rdata[95:64];
        py_d = mov_rdata[63:32];
        pz_d = mov_rdata[31:0];
        if (bw_q == '0) begin
          // zero bandwidth sends the point to the origin
          nx_d = '0; ny_d = '0; nz_d = '0;
          d2_d = '0; c_d = '0; dist_d = 1'b1;
          state_d = S_SQ;
        end else begin
          ax_d = '0; ay_d = '0; az_d = '0;
          wsum_d = '0;
          j_d = '0;
          state_d = S_SRC_RD;
        end
      end
      S_SRC_RD: state_d = S_SRC_LD;
      S_SRC_LD: begin
        sx_d = src_rdata[95:64];
        sy_d = src_rdata[63:32];
        sz_d = src_rdata[31:0];
        d2_d = '0;
        c_d = '0;
        dist_d = 1'b0;
        state_d = S_SQ;
      end
      S_SQ: begin
        mul_a = {1'b0, sq_mag};
        mul_b = {1'b0, sq_mag};
        d2_d = sq_sum[64] ? '1 : sq_sum[63:0];
        if (c_q == 2'd2) begin
          c_d = '0;
          state_d = dist_q ? S_PT_WR : S_KCHK;
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      S_KCHK: begin
        if ({4'b0, d2_q} >= {den_q, 5'b0}) begin
          // ratio of 32 or more gives zero weight
          if (last_j) begin
            state_d = S_MEAN;
          end else begin
            j_d = j_q + IW'(1);
            state_d = S_SRC_RD;
          end
        end else begin
          rem_d = {d2_q, 16'b0};
          dvs_d = {den_q, 20'b0};
          r_d = '0;
          k_d = 5'd20;
          state_d = S_KDIV;
        end
      end
      S_KDIV: begin
        if (div_ge) begin
          rem_d = rem_sub;
        end
        r_d = {r_q[19:0], div_ge};
        dvs_d = dvs_q >> 1;
        if (k_q == '0) begin
          w_d = 33'h1_0000_0000;
          state_d = S_KEXP;
        end else begin
          k_d = k_q - 5'd1;
        end
      end
      S_KEXP: begin
        mul_a = {1'b0, w_q};
        mul_b = {2'b0, EXP_TAB[k_q]};
        if (r_q[k_q]) begin
          w_d = exp_rnd[64:32];
        end
        if (k_q == 5'(EXP_BITS - 1)) begin
          c_d = '0;
          state_d = S_ACC;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      S_ACC: begin
        mul_a = {9'b0, wt};
        mul_b = {{2{sq_b[31]}}, sq_b};
        case (c_q)
          2'd0: begin
            ax_d = ax_q + mul_p[63:0];
            wsum_d = wsum_q + {6'b0, wt};
          end
          2'd1:    ay_d = ay_q + mul_p[63:0];
          default: az_d = az_q + mul_p[63:0];
        endcase
        if (c_q == 2'd2) begin
          c_d = '0;
          if (last_j) begin
            state_d = S_MEAN;
          end else begin
            j_d = j_q + IW'(1);
            state_d = S_SRC_RD;
          end
        end else begin
          c_d = c_q + 2'd1;
        end
      end
      S_MEAN: begin
        if (wsum_q == '0) begin
          // no weight at all: the point stays put
          nx_d = px_q; ny_d = py_q; nz_d = pz_q;
          d2_d = '0; c_d = '0; dist_d = 1'b1;
          state_d = S_SQ;
        end else begin
          c_d = '0;
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        neg_d = num[63];
        rem_d = {16'b0, num_mag + {34'b0, wsum_q[30:1]}};
        dvs_d = {21'b0, wsum_q, 31'b0};
        q_d = '0;
        k_d = 5'd31;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_ge) begin
          rem_d = rem_sub;
        end
        q_d = {q_q[30:0], div_ge};
        dvs_d = dvs_q >> 1;
        if (k_q == '0) begin
          case (c_q)
            2'd0:    nx_d = q_fin;
            2'd1:    ny_d = q_fin;
            default: nz_d = q_fin;
          endcase
          if (c_q == 2'd2) begin
            d2_d = '0; c_d = '0; dist_d = 1'b1;
            state_d = S_SQ;
          end else begin
            c_d = c_q + 2'd1;
            state_d = S_DIV_INIT;
          end
        end else begin
          k_d = k_q - 5'd1;
        end
      end
      S_PT_WR: begin
        mov_we = 1'b1;
        if (d2_q > worst_q) begin
          worst_d = d2_q;
        end
        if (d2_q < {32'b0, th2_q}) begin
          still_d[i_q] = 1'b0;
        end
        state_d = S_PT_NEXT;
      end
      S_PT_NEXT: begin
        if (last_i) begin
          passes_d = passes_q + 8'd1;
          state_d = S_PASS_END;
        end else begin
          i_d = i_q + IW'(1);
          state_d = S_PT_CHK;
        end
      end
      S_PASS_END: begin
        if ((worst_q > {32'b0, th2_q}) && (passes_q < lim_q)) begin
          state_d = S_PASS;
        end else begin
          i_d = '0;
          state_d = S_OUT_RD;
        end
      end
      S_OUT_RD: state_d = S_OUT;
      S_OUT: begin
        res_valid_d = 1'b1;
        res_d.mode_x = mov_rdata[95:64];
        res_d.mode_y = mov_rdata[63:32];
        res_d.mode_z = mov_rdata[31:0];
        res_d.final_point = last_i;
        res_d.passes_used = passes_q;
        if (last_i) begin
          cnt_d = '0;
          still_d = '1;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + IW'(1);
          state_d = S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      still_q <= '1;
      bw_q <= BANDWIDTH_RST;
      th_q <= THRESHOLD_RST;
      lim_q <= ITER_LIMIT_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      still_q <= still_d;
      bw_q <= bw_d;
      th_q <= th_d;
      lim_q <= lim_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    c_q <= c_d;
    k_q <= k_d;
    dist_q <= dist_d;
    neg_q <= neg_d;
    den_q <= den_d;
    th2_q <= th2_d;
    passes_q <= passes_d;
    px_q <= px_d; py_q <= py_d; pz_q <= pz_d;
    sx_q <= sx_d; sy_q <= sy_d; sz_q <= sz_d;
    nx_q <= nx_d; ny_q <= ny_d; nz_q <= nz_d;
    d2_q <= d2_d;
    worst_q <= worst_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    r_q <= r_d;
    w_q <= w_d;
    q_q <= q_d;
    ax_q <= ax_d; ay_q <= ay_d; az_q <= az_d;
    wsum_q <= wsum_d;
    res_q <= res_d;
  end

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msc_pkg::*;

  localparam int unsigned NPTS = 64;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         item_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_BANDWIDTH;
  logic [31:0] cfg_data_i = '0;

  mean_shift_cluster_engine #(.MAX_POINTS(NPTS)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // own copy of the engine state
  logic signed [31:0] src_x [NPTS];
  logic signed [31:0] src_y [NPTS];
  logic signed [31:0] src_z [NPTS];
  int unsigned n_loaded = 0;
  logic [30:0] bw_q = BANDWIDTH_RST;
  logic [15:0] th_q = THRESHOLD_RST;
  logic [7:0]  lim_q = ITER_LIMIT_RST;

  out_t modes_due [$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  longint unsigned cycles = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic longint unsigned diff_sq(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    longint unsigned m;
    d = longint'(a) - longint'(b);
    m = (d < 0) ? longint'(-d) : d;
    return m * m;
  endfunction

  function automatic longint unsigned dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                              logic signed [31:0] az, logic signed [31:0] bx,
                                              logic signed [31:0] by, logic signed [31:0] bz);
    longint unsigned s, t;
    s = diff_sq(ax, bx);
    t = s + diff_sq(ay, by);
    s = (t < s) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
    t = s + diff_sq(az, bz);
    return (t < s) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
  endfunction

  // gaussian weight in q1.24, ratio built by restoring division to q5.16
  function automatic longint unsigned gauss_weight(longint unsigned d2, longint unsigned den);
    longint unsigned ip, rem, r, w;
    ip = d2 / den;
    if (ip >= 32) return 0;
    rem = d2 - ip * den;
    r = ip;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      r = r << 1;
      if (rem >= den) begin
        rem -= den;
        r |= 1;
      end
    end
    w = 64'd1 << 32;
    for (int i = 0; i < EXP_BITS; i++)
      if (r[i]) w = (w * longint'(EXP_TAB[i]) + (64'd1 << 31)) >> 32;
    return (w + 128) >> 8;
  endfunction

  function automatic logic signed [31:0] round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    longint res;
    mag = (num < 0) ? (64'd0 - num) : num;
    q = (mag + den / 2) / den;
    res = (num < 0) ? -longint'(q) : longint'(q);
    return res[31:0];
  endfunction

  function automatic void shift_point(int unsigned n, inout logic signed [31:0] x,
                                      inout logic signed [31:0] y, inout logic signed [31:0] z);
    longint unsigned den, w, wsum;
    longint ax, ay, az;
    if (bw_q == 0) begin
      x = 0; y = 0; z = 0;
      return;
    end
    den = 2 * longint'(bw_q) * longint'(bw_q);
    wsum = 0; ax = 0; ay = 0; az = 0;
    for (int unsigned i = 0; i < n; i++) begin
      w = gauss_weight(dist_sq(x, y, z, src_x[i], src_y[i], src_z[i]), den);
      ax += longint'(w) * longint'(src_x[i]);
      ay += longint'(w) * longint'(src_y[i]);
      az += longint'(w) * longint'(src_z[i]);
      wsum += w;
    end
    // an empty neighbourhood leaves the point where it is
    if (wsum == 0) return;
    x = round_div(ax, wsum);
    y = round_div(ay, wsum);
    z = round_div(az, wsum);
  endfunction

  function automatic void predict_modes(in_t it, ref out_t res[$]);
    logic signed [31:0] mx [NPTS];
    logic signed [31:0] my [NPTS];
    logic signed [31:0] mz [NPTS];
    logic signed [31:0] x, y, z;
    bit moving [NPTS];
    longint unsigned th2, worst, d2;
    int unsigned n, passes;
    out_t o;
    res = {};
    if (n_loaded < NPTS) begin
      src_x[n_loaded] = it.coord_x;
      src_y[n_loaded] = it.coord_y;
      src_z[n_loaded] = it.coord_z;
      n_loaded++;
    end
    if (!it.set_end) return;
    n = n_loaded;
    th2 = longint'(th_q) * longint'(th_q);
    for (int unsigned i = 0; i < n; i++) begin
      mx[i] = src_x[i]; my[i] = src_y[i]; mz[i] = src_z[i];
      moving[i] = 1'b1;
    end
    passes = 0;
    do begin
      worst = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (moving[i]) begin
          x = mx[i]; y = my[i]; z = mz[i];
          shift_point(n, x, y, z);
          d2 = dist_sq(x, y, z, mx[i], my[i], mz[i]);
          if (d2 > worst) worst = d2;
          if (d2 < th2) moving[i] = 1'b0;
          mx[i] = x; my[i] = y; mz[i] = z;
        end
      end
      passes++;
    end while (worst > th2 && passes < lim_q);
    for (int unsigned i = 0; i < n; i++) begin
      o.mode_x = mx[i];
      o.mode_y = my[i];
      o.mode_z = mz[i];
      o.final_point = (i + 1 == n);
      o.passes_used = passes[7:0];
      res.push_back(o);
    end
    n_loaded = 0;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (modes_due.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = modes_due.pop_front();
        if (result_o.mode_x !== want.mode_x)
          report_mismatch($sformatf("mode_x %h want %h", result_o.mode_x, want.mode_x));
        if (result_o.mode_y !== want.mode_y)
          report_mismatch($sformatf("mode_y %h want %h", result_o.mode_y, want.mode_y));
        if (result_o.mode_z !== want.mode_z)
          report_mismatch($sformatf("mode_z %h want %h", result_o.mode_z, want.mode_z));
        if (result_o.final_point !== want.final_point)
          report_mismatch($sformatf("final_point %b want %b", result_o.final_point,
                                    want.final_point));
        if (result_o.passes_used !== want.passes_used)
          report_mismatch($sformatf("passes_used %0d want %0d", result_o.passes_used,
                                    want.passes_used));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one point word; an optional typed expectation replaces the predicted one
  task automatic send_point(input in_t it, input bit typed = 0, input out_t w0 = '0,
                            input out_t w1 = '0, input int n_typed = 0);
    out_t res [$];
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_modes(it, res);
    if (typed) begin
      if (n_typed > 0) modes_due.push_back(w0);
      if (n_typed > 1) modes_due.push_back(w1);
    end else begin
      foreach (res[i]) modes_due.push_back(res[i]);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    start <= 1'b0;
    @(posedge clk_i);
    while (modes_due.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BANDWIDTH:  bw_q = data[30:0];
      CFG_THRESHOLD:  th_q = data[15:0];
      CFG_ITER_LIMIT: lim_q = data[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit e);
    in_t it;
    it.coord_x = x; it.coord_y = y; it.coord_z = z; it.set_end = e;
    return it;
  endfunction

  function automatic out_t mo(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit f,
                              logic [7:0] p);
    out_t o;
    o.mode_x = x; o.mode_y = y; o.mode_z = z; o.final_point = f; o.passes_used = p;
    return o;
  endfunction

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    in_t         it;
    int          n_typed;
    out_t        w0;
    out_t        w1;
  } row_t;

  row_t rows [$];

  function automatic void add_cfg(logic [1:0] idx, logic [31:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.idx = idx; r.data = data;
    rows.push_back(r);
  endfunction

  function automatic void add_pt(in_t it, int n_typed = 0, out_t w0 = '0, out_t w1 = '0);
    row_t r;
    r = '{default: '0};
    r.it = it; r.n_typed = n_typed; r.w0 = w0; r.w1 = w1;
    rows.push_back(r);
  endfunction

  initial begin
    int n_set, spread;
    logic [31:0] cx, cy, cz;
    bit wild;

    // lone point stays put after one pass at reset defaults
    add_pt(mk(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1), 1,
           mo(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1, 1));
    add_pt(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1), 1,
           mo(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1));
    add_pt(mk(32'h0, 32'h0, 32'h0, 0));
    add_pt(mk(32'h0000_8000, 32'hFFFF_C000, 32'h0001_0000, 0));
    add_pt(mk(32'h0003_0000, 32'h0, 32'hFFFF_0000, 1));
    // zero bandwidth: everything collapses onto the origin in two passes
    add_cfg(CFG_BANDWIDTH, 32'h0);
    add_pt(mk(32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 0));
    add_pt(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 2,
           mo(0, 0, 0, 0, 2), mo(0, 0, 0, 1, 2));
    // widest kernel, coarsest threshold, limit of zero acts as one
    add_cfg(CFG_BANDWIDTH, 32'hFFFF_FFFF);
    add_cfg(CFG_THRESHOLD, 32'h0000_FFFF);
    add_cfg(CFG_ITER_LIMIT, 32'h0);
    add_pt(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    add_pt(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    // zero threshold with the largest pass count
    add_cfg(CFG_BANDWIDTH, 32'h0001_0000);
    add_cfg(CFG_THRESHOLD, 32'h0);
    add_cfg(CFG_ITER_LIMIT, 32'hFF);
    add_pt(mk(32'h0, 32'h0, 32'h0, 0));
    add_pt(mk(32'h0001_0000, 32'h0, 32'h0, 1));
    // narrowest kernel: far points weigh nothing
    add_cfg(CFG_BANDWIDTH, 32'h1);
    add_cfg(CFG_THRESHOLD, 32'h1);
    add_cfg(CFG_ITER_LIMIT, 32'h3);
    add_pt(mk(32'h0, 32'h0, 32'h0, 0));
    add_pt(mk(32'h0000_0001, 32'h0, 32'h0, 0));
    add_pt(mk(32'h4000_0000, 32'hC000_0000, 32'h2000_0000, 1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_point(rows[i].it, rows[i].n_typed > 0, rows[i].w0, rows[i].w1,
                      rows[i].n_typed);
    end

    // overfull set: the word past capacity, set_end included, is dropped but starts the run
    write_reg(CFG_BANDWIDTH, 32'h0004_0000);
    write_reg(CFG_ITER_LIMIT, 32'h1);
    for (int i = 0; i <= NPTS; i++)
      send_point(mk($urandom_range(0, 32'h000F_FFFF), $urandom, $urandom_range(0, 32'hFFFF),
                    i == NPTS));

    // random sets, mostly clustered around a centre, some with raw full-range words
    for (int k = 0; k < 8; k++) begin
      case (k / 2)
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 0;
        default: idle_pct = 36;
      endcase
      case ($urandom_range(5))
        0: write_reg(CFG_BANDWIDTH, $urandom);
        1: write_reg(CFG_BANDWIDTH, 32'h0);
        default: write_reg(CFG_BANDWIDTH, $urandom_range(32'h0000_4000, 32'h0004_0000));
      endcase
      write_reg(CFG_THRESHOLD, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 64));
      write_reg(CFG_ITER_LIMIT, ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 12));
      n_set = $urandom_range(1, 4);
      wild = ($urandom_range(4) == 0);
      spread = $urandom_range(12, 19);
      cx = $urandom; cy = $urandom; cz = $urandom;
      for (int i = 0; i < n_set; i++) begin
        if (wild)
          send_point(mk($urandom, $urandom, $urandom, i == n_set - 1));
        else
          send_point(mk(cx + ($urandom >> (31 - spread)) - (32'h1 << (spread - 1)),
                        cy + ($urandom >> (31 - spread)) - (32'h1 << (spread - 1)),
                        cz + ($urandom >> (31 - spread)) - (32'h1 << (spread - 1)),
                        i == n_set - 1));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (modes_due.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
